// ===== design/hptc_pkg.sv =====
// shared types, constants and register codes for the heading pid turn controller
package hptc_pkg;

  localparam int ANGLE_W   = 17;
  localparam int HEAD_W    = 16;
  localparam int TGT_W     = 16;
  localparam int ERR_W     = 16;
  localparam int MAG_W     = 15;
  localparam int SUM_W     = 32;
  localparam int DERIV_W   = 17;
  localparam int DRIVE_W   = 15;
  localparam int GAIN_W    = 24;
  localparam int TOL_W     = 15;
  localparam int PLIM_W    = 14;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;
  localparam int KIND_W    = 2;

  localparam int PROD_P_W  = GAIN_W + 1 + ERR_W;
  localparam int PROD_I_W  = GAIN_W + 1 + SUM_W;
  localparam int PROD_D_W  = GAIN_W + 1 + DERIV_W;
  localparam int ACC_W     = PROD_I_W + 1;
  localparam int FRAC_W    = 16;
  localparam int SHIFT_W   = ACC_W - FRAC_W;

  localparam int FULL_TURN   = 36000;
  localparam int HALF_TURN   = 18000;
  localparam int MAX_HEADING = 35999;

  localparam logic [GAIN_W-1:0] GAIN_P_RST      = GAIN_W'(65536);
  localparam logic [GAIN_W-1:0] GAIN_I_RST      = '0;
  localparam logic [GAIN_W-1:0] GAIN_D_RST      = '0;
  localparam logic [TOL_W-1:0]  TOLERANCE_RST   = TOL_W'(100);
  localparam logic [PLIM_W-1:0] POWER_LIMIT_RST = PLIM_W'(10000);

  typedef enum logic [KIND_W-1:0] {
    KIND_ABS    = 2'd0,
    KIND_SAMPLE = 2'd1,
    KIND_REL    = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P      = 3'd0,
    REG_GAIN_I      = 3'd1,
    REG_GAIN_D      = 3'd2,
    REG_TOLERANCE   = 3'd3,
    REG_POWER_LIMIT = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0] gain_p;
    logic [GAIN_W-1:0] gain_i;
    logic [GAIN_W-1:0] gain_d;
    logic [TOL_W-1:0]  tolerance;
    logic [PLIM_W-1:0] power_limit;
  } cfg_t;

  typedef struct packed {
    logic                      pid;
    logic                      done;
    logic signed [ERR_W-1:0]   err;
    logic signed [SUM_W-1:0]   esum;
    logic signed [DERIV_W-1:0] deriv;
  } track_t;

endpackage

// ===== design/heading_pid_turn_controller.sv =====
// heading pid turn controller top level: input register, tracking stage, product stage, result register
// an accepted input transaction passes the tracking, product and result registers before out_valid
// throughput: one transaction per cycle unless out_stall holds the result; the move state updates
// in the tracking stage, so each transaction sees the state left by the one before it
// a stalled result holds its register while the earlier stages keep filling
// reset (synchronous, rst_n low) empties the pipeline, clears the move state, loads default gains
module heading_pid_turn_controller import hptc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [KIND_W-1:0]         in_kind,
  input  logic signed [ANGLE_W-1:0] in_angle,
  input  logic [HEAD_W-1:0]         in_heading,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [DRIVE_W-1:0] out_drive,
  output logic                      out_done_res,
  output logic signed [ERR_W-1:0]   out_error_out,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_wdata
);

  logic v_in_r, v_trk_r, v_mul_r, v_out_r;
  logic rdy_in, rdy_trk, rdy_mul, rdy_out;
  logic take_in, adv_trk, adv_mul, adv_out;

  logic [KIND_W-1:0]         kind_r;
  logic signed [ANGLE_W-1:0] angle_r;
  logic [HEAD_W-1:0]         heading_r;

  cfg_t   cfg;
  track_t trk;

  assign rdy_out = !v_out_r || !out_stall;
  assign rdy_mul = !v_mul_r || rdy_out;
  assign rdy_trk = !v_trk_r || rdy_mul;
  assign rdy_in  = !v_in_r || rdy_trk;

  assign take_in = in_valid && rdy_in;
  assign adv_trk = v_in_r && rdy_trk;
  assign adv_mul = v_trk_r && rdy_mul;
  assign adv_out = v_mul_r && rdy_out;

  assign in_stall  = !rdy_in;
  assign out_valid = v_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_in_r  <= 1'b0;
      v_trk_r <= 1'b0;
      v_mul_r <= 1'b0;
      v_out_r <= 1'b0;
    end else begin
      if (rdy_in)  v_in_r  <= in_valid;
      if (rdy_trk) v_trk_r <= v_in_r;
      if (rdy_mul) v_mul_r <= v_trk_r;
      if (rdy_out) v_out_r <= v_mul_r;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      kind_r    <= in_kind;
      angle_r   <= in_angle;
      heading_r <= in_heading;
    end
  end

  hptc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  hptc_track u_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv_trk),
    .kind      (kind_r),
    .angle     (angle_r),
    .heading   (heading_r),
    .tolerance (cfg.tolerance),
    .trk       (trk)
  );

  hptc_drive u_drive (
    .clk     (clk),
    .adv_mul (adv_mul),
    .adv_out (adv_out),
    .trk     (trk),
    .cfg     (cfg),
    .drive   (out_drive),
    .done    (out_done_res),
    .err     (out_error_out)
  );

endmodule

// ===== design/hptc_cfg.sv =====
// configuration register file: gains, tolerance and power limit
module hptc_cfg import hptc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output cfg_t                 cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p      <= GAIN_P_RST;
      cfg_r.gain_i      <= GAIN_I_RST;
      cfg_r.gain_d      <= GAIN_D_RST;
      cfg_r.tolerance   <= TOLERANCE_RST;
      cfg_r.power_limit <= POWER_LIMIT_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_GAIN_P:      cfg_r.gain_p      <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_I:      cfg_r.gain_i      <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_D:      cfg_r.gain_d      <= cfg_wdata[GAIN_W-1:0];
        REG_TOLERANCE:   cfg_r.tolerance   <= cfg_wdata[TOL_W-1:0];
        REG_POWER_LIMIT: cfg_r.power_limit <= cfg_wdata[PLIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== design/hptc_track.sv =====
// move tracking: target load, wrapped error, integral and derivative, move state
module hptc_track import hptc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  logic [KIND_W-1:0]         kind,
  input  logic signed [ANGLE_W-1:0] angle,
  input  logic [HEAD_W-1:0]         heading,
  input  logic [TOL_W-1:0]          tolerance,
  output track_t                    trk
);

  logic [TGT_W-1:0]          target_r, target_nxt;
  logic signed [SUM_W-1:0]   esum_r, esum_nxt;
  logic signed [ERR_W-1:0]   prev_r, prev_nxt;
  logic                      moving_r, moving_nxt;
  track_t                    trk_r, trk_nxt;

  logic signed [ANGLE_W:0]   angle_x, angle_c;
  logic [HEAD_W-1:0]         head_c;
  logic signed [ANGLE_W+1:0] tgt_raw, tgt_a, tgt_b;
  logic signed [ANGLE_W:0]   err_raw, err_w;
  logic signed [ERR_W-1:0]   err;
  logic [MAG_W-1:0]          mag;
  logic signed [SUM_W:0]     sum_x;
  logic signed [SUM_W-1:0]   sum_sat;
  logic signed [DERIV_W-1:0] deriv;

  always_comb begin
    angle_x = (ANGLE_W+1)'(angle);
    if (angle_x > (ANGLE_W+1)'(FULL_TURN)) begin
      angle_c = (ANGLE_W+1)'(FULL_TURN);
    end else if (angle_x < -(ANGLE_W+1)'(FULL_TURN)) begin
      angle_c = -(ANGLE_W+1)'(FULL_TURN);
    end else begin
      angle_c = angle_x;
    end

    head_c = (heading > HEAD_W'(MAX_HEADING)) ? HEAD_W'(MAX_HEADING) : heading;

    // relative turn is taken from the measured heading
    if (kind_t'(kind) == KIND_REL) begin
      tgt_raw = (ANGLE_W+2)'(angle_c) + $signed({3'b000, head_c});
    end else begin
      tgt_raw = (ANGLE_W+2)'(angle_c);
    end
    tgt_a = (tgt_raw < 0) ? tgt_raw + (ANGLE_W+2)'(FULL_TURN) : tgt_raw;
    tgt_b = (tgt_a > (ANGLE_W+2)'(FULL_TURN)) ? tgt_a - (ANGLE_W+2)'(FULL_TURN) : tgt_a;

    // shortest path error
    err_raw = $signed({2'b00, target_r}) - $signed({2'b00, head_c});
    if (err_raw > (ANGLE_W+1)'(HALF_TURN)) begin
      err_w = err_raw - (ANGLE_W+1)'(FULL_TURN);
    end else if (err_raw < -(ANGLE_W+1)'(HALF_TURN)) begin
      err_w = err_raw + (ANGLE_W+1)'(FULL_TURN);
    end else begin
      err_w = err_raw;
    end
    err = err_w[ERR_W-1:0];
    mag = (err_w < 0) ? MAG_W'(-err_w) : err_w[MAG_W-1:0];

    // saturating integral
    sum_x = (SUM_W+1)'(esum_r) + (SUM_W+1)'(err);
    if (sum_x[SUM_W] != sum_x[SUM_W-1]) begin
      sum_sat = sum_x[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_sat = sum_x[SUM_W-1:0];
    end
    deriv = DERIV_W'(err) - DERIV_W'(prev_r);
  end

  always_comb begin
    target_nxt = target_r;
    esum_nxt   = esum_r;
    prev_nxt   = prev_r;
    moving_nxt = moving_r;
    trk_nxt    = '0;
    case (kind_t'(kind))
      KIND_ABS, KIND_REL: begin
        target_nxt = tgt_b[TGT_W-1:0];
        esum_nxt   = '0;
        prev_nxt   = '0;
        moving_nxt = 1'b1;
      end
      KIND_SAMPLE: begin
        trk_nxt.err = err;
        if (!moving_r) begin
          trk_nxt.done = 1'b1;
        end else if (mag < tolerance) begin
          moving_nxt   = 1'b0;
          trk_nxt.done = 1'b1;
        end else begin
          esum_nxt      = sum_sat;
          prev_nxt      = err;
          trk_nxt.pid   = 1'b1;
          trk_nxt.esum  = sum_sat;
          trk_nxt.deriv = deriv;
        end
      end
      default: begin
        trk_nxt.done = !moving_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
      esum_r   <= '0;
      prev_r   <= '0;
      moving_r <= 1'b0;
    end else if (adv) begin
      target_r <= target_nxt;
      esum_r   <= esum_nxt;
      prev_r   <= prev_nxt;
      moving_r <= moving_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      trk_r <= trk_nxt;
    end
  end

  assign trk = trk_r;

endmodule

// ===== design/hptc_drive.sv =====
// drive datapath: registered gain products, then sum, shift and clamp into the result register
module hptc_drive import hptc_pkg::*; (
  input  logic                      clk,
  input  logic                      adv_mul,
  input  logic                      adv_out,
  input  track_t                    trk,
  input  cfg_t                      cfg,
  output logic signed [DRIVE_W-1:0] drive,
  output logic                      done,
  output logic signed [ERR_W-1:0]   err
);

  logic signed [PROD_P_W-1:0] prod_p_r;
  logic signed [PROD_I_W-1:0] prod_i_r;
  logic signed [PROD_D_W-1:0] prod_d_r;
  logic                       pid_r;
  logic                       done_m_r;
  logic signed [ERR_W-1:0]    err_m_r;

  logic signed [ACC_W-1:0]    acc;
  logic signed [SHIFT_W-1:0]  shifted;
  logic signed [SHIFT_W-1:0]  lim_x;
  logic signed [DRIVE_W-1:0]  lim;
  logic signed [DRIVE_W-1:0]  drive_nxt;

  logic signed [DRIVE_W-1:0]  drive_r;
  logic                       done_r;
  logic signed [ERR_W-1:0]    err_r;

  always_ff @(posedge clk) begin
    if (adv_mul) begin
      prod_p_r <= $signed({1'b0, cfg.gain_p}) * trk.err;
      prod_i_r <= $signed({1'b0, cfg.gain_i}) * trk.esum;
      prod_d_r <= $signed({1'b0, cfg.gain_d}) * trk.deriv;
      pid_r    <= trk.pid;
      done_m_r <= trk.done;
      err_m_r  <= trk.err;
    end
  end

  always_comb begin
    acc     = ACC_W'(prod_p_r) + ACC_W'(prod_i_r) + ACC_W'(prod_d_r);
    // arithmetic shift rounds toward minus infinity
    shifted = acc[ACC_W-1:FRAC_W];
    lim     = $signed({1'b0, cfg.power_limit});
    lim_x   = SHIFT_W'(lim);
    if (!pid_r) begin
      drive_nxt = '0;
    end else if (shifted > lim_x) begin
      drive_nxt = lim;
    end else if (shifted < -lim_x) begin
      drive_nxt = -lim;
    end else begin
      drive_nxt = shifted[DRIVE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out) begin
      drive_r <= drive_nxt;
      done_r  <= done_m_r;
      err_r   <= err_m_r;
    end
  end

  assign drive = drive_r;
  assign done  = done_r;
  assign err   = err_r;

endmodule

// ===== design/hptc_chk.sv =====
// port-level checker for the heading pid turn controller and its bind
module hptc_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [14:0] out_drive,
  input logic               out_done_res,
  input logic signed [15:0] out_error_out
);

  // a stalled result transaction stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result transaction dropped while stalled");

  // a finished or idle move never drives the motors
  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> out_drive == 15'sd0)
    else $error("nonzero drive with done set");

  // the reported error is on the shortest path
  a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_error_out <= 16'sd18000) && (out_error_out >= -16'sd18000))
    else $error("heading error out of half turn range");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind heading_pid_turn_controller hptc_chk u_hptc_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_drive     (out_drive),
  .out_done_res  (out_done_res),
  .out_error_out (out_error_out)
);

// ===== sim/tb_heading_pid_turn_controller.sv =====
// self-checking testbench for the heading pid turn controller
module tb_heading_pid_turn_controller;
  import hptc_pkg::*;

  localparam int CYCLE_LIMIT = 100_000;
  localparam int REPORT_CAP = 30;
  localparam int INTEG_SAMPLES = 20;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam logic [GAIN_W-1:0] GAIN_MAX = '1;
  localparam logic [TOL_W-1:0] TOL_MAX = '1;
  localparam logic [PLIM_W-1:0] PLIM_MAX = '1;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      done;
    logic signed [ERR_W-1:0]   err;
  } turn_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [KIND_W-1:0] in_kind = KIND_ABS;
  logic signed [ANGLE_W-1:0] in_angle = '0;
  logic [HEAD_W-1:0] in_heading = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [DRIVE_W-1:0] out_drive;
  logic out_done_res;
  logic signed [ERR_W-1:0] out_error_out;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_GAIN_P;
  logic [CFG_W-1:0] cfg_wdata = '0;

  heading_pid_turn_controller dut (.*);

  // controller copy: configuration and move state
  longint gain_p_q, gain_i_q, gain_d_q;
  int tol_q, plim_q;
  int target_q, esum_q, last_err_q;
  bit moving_q;

  turn_result_t expected_turns[$];
  turn_result_t head_turn;
  int fail_count = 0;
  int checks_done = 0;
  int items_sent = 0;
  int moves_finished = 0;
  int cycle_count = 0;

  bit pace_on = 1'b0;
  int burst_left = 0;
  bit stall_on = 1'b0;
  bit stall_now = 1'b0;
  int stall_run = 0;
  int hold_req = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("heading_pid_turn_controller test failed");
      $finish;
    end
  end

  function automatic turn_result_t predict_turn(logic [KIND_W-1:0] k,
                                                logic signed [ANGLE_W-1:0] ang,
                                                logic [HEAD_W-1:0] hd);
    int a, h, e, mag, t, d;
    longint s, acc;
    turn_result_t r;
    r = '0;
    a = int'(ang);
    if (a < -FULL_TURN) a = -FULL_TURN;
    if (a > FULL_TURN) a = FULL_TURN;
    h = int'(hd);
    if (h > MAX_HEADING) h = MAX_HEADING;
    if (k == KIND_ABS || k == KIND_REL) begin
      t = (k == KIND_REL) ? a + h : a;
      if (t < 0) t += FULL_TURN;
      if (t > FULL_TURN) t -= FULL_TURN;
      target_q = t;
      esum_q = 0;
      last_err_q = 0;
      moving_q = 1'b1;
    end else if (k == KIND_SAMPLE) begin
      e = target_q - h;
      if (e > HALF_TURN) e -= FULL_TURN;
      if (e < -HALF_TURN) e += FULL_TURN;
      mag = (e < 0) ? -e : e;
      r.err = ERR_W'(e);
      if (!moving_q) begin
        r.done = 1'b1;
      end else if (mag < tol_q) begin
        moving_q = 1'b0;
        r.done = 1'b1;
        moves_finished++;
      end else begin
        s = longint'(esum_q) + e;
        if (s > 64'sd2147483647) s = 64'sd2147483647;
        if (s < -64'sd2147483648) s = -64'sd2147483648;
        esum_q = int'(s);
        d = e - last_err_q;
        acc = gain_p_q * e + gain_i_q * esum_q + gain_d_q * d;
        acc = acc >>> FRAC_W;
        if (acc > plim_q) acc = plim_q;
        if (acc < -plim_q) acc = -plim_q;
        r.drive = DRIVE_W'(acc);
        last_err_q = e;
      end
    end else begin
      r.done = !moving_q;
    end
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (expected_turns.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_CAP) $error("result transaction with nothing expected");
      end else begin
        head_turn = expected_turns.pop_front();
        checks_done++;
        if (out_drive !== head_turn.drive) begin
          fail_count++;
          if (fail_count <= REPORT_CAP)
            $error("drive: expected %0d, got %0d", head_turn.drive, out_drive);
        end
        if (out_done_res !== head_turn.done) begin
          fail_count++;
          if (fail_count <= REPORT_CAP)
            $error("done_res: expected %0d, got %0d", head_turn.done, out_done_res);
        end
        if (out_error_out !== head_turn.err) begin
          fail_count++;
          if (fail_count <= REPORT_CAP)
            $error("error_out: expected %0d, got %0d", head_turn.err, out_error_out);
        end
      end
    end
  end

  // receiver stall pattern, with an optional long hold-off
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        out_stall <= 1'b1;
        repeat (hold_req) @(posedge clk);
        hold_req = 0;
      end else if (!stall_on) begin
        out_stall <= 1'b0;
      end else begin
        if (stall_run == 0) begin
          stall_now = !stall_now;
          stall_run = stall_now ? $urandom_range(1, 6) : $urandom_range(1, 10);
        end
        stall_run--;
        out_stall <= stall_now;
      end
    end
  end

  task automatic send_turn_item(logic [KIND_W-1:0] k, logic signed [ANGLE_W-1:0] ang,
                                logic [HEAD_W-1:0] hd);
    int gap;
    if (pace_on) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 6);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
    end
    in_valid <= 1'b1;
    in_kind <= k;
    in_angle <= ang;
    in_heading <= hd;
    do @(posedge clk); while (in_stall);
    expected_turns.push_back(predict_turn(k, ang, hd));
    items_sent++;
  endtask

  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (expected_turns.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_config(logic [GAIN_W-1:0] gp, logic [GAIN_W-1:0] gi,
                              logic [GAIN_W-1:0] gd, logic [TOL_W-1:0] tol,
                              logic [PLIM_W-1:0] plim);
    reg_idx_t order[5];
    logic [CFG_W-1:0] vals[5];
    order = '{REG_GAIN_P, REG_GAIN_I, REG_GAIN_D, REG_TOLERANCE, REG_POWER_LIMIT};
    vals = '{gp, gi, gd, CFG_W'(tol), CFG_W'(plim)};
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= order[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    gain_p_q = longint'(gp);
    gain_i_q = longint'(gi);
    gain_d_q = longint'(gd);
    tol_q = int'(tol);
    plim_q = int'(plim);
  endtask

  function automatic logic [HEAD_W-1:0] heading_near(int spread);
    int h;
    h = target_q + int'($urandom_range(0, 2 * spread)) - spread;
    h = ((h % FULL_TURN) + FULL_TURN) % FULL_TURN;
    return HEAD_W'(h);
  endfunction

  function automatic logic signed [ANGLE_W-1:0] random_angle();
    if ($urandom_range(0, 9) == 0) return ANGLE_W'($urandom());
    return ANGLE_W'(int'($urandom_range(0, 2 * FULL_TURN)) - FULL_TURN);
  endfunction

  function automatic logic [HEAD_W-1:0] random_heading();
    if ($urandom_range(0, 9) == 0) return HEAD_W'($urandom());
    return HEAD_W'($urandom_range(0, MAX_HEADING));
  endfunction

  task automatic test_defaults_and_wrap();
    send_turn_item(KIND_SAMPLE, 0, 0);
    send_turn_item(KIND_UNUSED, '1, '1);
    send_turn_item(KIND_ABS, 9000, 0);
    send_turn_item(KIND_SAMPLE, 0, 0);
    send_turn_item(KIND_UNUSED, 0, 0);
    send_turn_item(KIND_SAMPLE, 0, 8950);
    send_turn_item(KIND_SAMPLE, 0, 0);
    send_turn_item(KIND_REL, -36000, 100);
    send_turn_item(KIND_SAMPLE, 0, 35000);
    send_turn_item(KIND_ABS, 35000, 0);
    send_turn_item(KIND_SAMPLE, 0, 100);
    send_turn_item(KIND_ABS, 36000, 0);
    send_turn_item(KIND_SAMPLE, 0, '1);
    send_turn_item(KIND_ABS, 17'h10000, 0);
    send_turn_item(KIND_SAMPLE, 0, 18000);
    send_turn_item(KIND_ABS, 17'h0ffff, 0);
    send_turn_item(KIND_SAMPLE, 0, 18000);
    send_turn_item(KIND_REL, 36000, 35999);
    send_turn_item(KIND_SAMPLE, 0, 0);
    drain_pipeline();
  endtask

  task automatic test_config_extremes();
    write_config(GAIN_MAX, GAIN_MAX, GAIN_MAX, '0, '0);
    send_turn_item(KIND_ABS, 9000, 0);
    send_turn_item(KIND_SAMPLE, 0, 0);
    send_turn_item(KIND_SAMPLE, 0, 9000);
    drain_pipeline();
    write_config(GAIN_MAX, GAIN_MAX, GAIN_MAX, TOL_MAX, PLIM_MAX);
    send_turn_item(KIND_ABS, 0, 0);
    send_turn_item(KIND_SAMPLE, 0, 18000);
    drain_pipeline();
    write_config(GAIN_MAX, '0, '0, '0, PLIM_MAX);
    send_turn_item(KIND_ABS, 18000, 0);
    send_turn_item(KIND_SAMPLE, 0, 0);
    send_turn_item(KIND_SAMPLE, 0, 35999);
    drain_pipeline();
    write_config('0, '0, GAIN_MAX, '0, PLIM_W'(10000));
    send_turn_item(KIND_ABS, 18000, 0);
    send_turn_item(KIND_SAMPLE, 0, 0);
    send_turn_item(KIND_SAMPLE, 0, 0);
    drain_pipeline();
  endtask

  task automatic test_integral_windup();
    write_config('0, GAIN_W'(1), '0, TOL_W'(100), PLIM_W'(10000));
    pace_on = 1'b0;
    stall_on = 1'b0;
    send_turn_item(KIND_ABS, 18000, 0);
    repeat (INTEG_SAMPLES) send_turn_item(KIND_SAMPLE, 0, 0);
    send_turn_item(KIND_ABS, 0, 0);
    repeat (INTEG_SAMPLES) send_turn_item(KIND_SAMPLE, 0, 18000);
    drain_pipeline();
  endtask

  task automatic test_backpressure();
    write_config(GAIN_P_RST, GAIN_W'(16), GAIN_W'(4096), TOLERANCE_RST, POWER_LIMIT_RST);
    pace_on = 1'b0;
    hold_req = 200;
    send_turn_item(KIND_REL, 4500, 1000);
    repeat (40) send_turn_item(KIND_SAMPLE, 0, heading_near(3000));
    drain_pipeline();
  endtask

  task automatic test_random_moves();
    int sent, n, pick;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: write_config(GAIN_P_RST, GAIN_I_RST, GAIN_D_RST, TOLERANCE_RST, POWER_LIMIT_RST);
        4: write_config(GAIN_W'($urandom()), GAIN_W'($urandom()), GAIN_W'($urandom()),
                        TOL_W'($urandom()), PLIM_W'($urandom()));
        default: write_config(GAIN_W'($urandom_range(0, 24'h60000)),
                              GAIN_W'($urandom_range(0, 24'h200)),
                              GAIN_W'($urandom_range(0, 24'h80000)),
                              TOL_W'($urandom_range(0, 1500)),
                              PLIM_W'($urandom_range(0, 16383)));
      endcase
      pace_on = (phase != 1);
      stall_on = (phase != 2);
      sent = 0;
      while (sent < 80) begin
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
          send_turn_item(KIND_ABS, random_angle(), HEAD_W'($urandom()));
          sent++;
        end else if (pick < 8) begin
          send_turn_item(KIND_REL, random_angle(), random_heading());
          sent++;
        end else if (pick == 8) begin
          send_turn_item(KIND_UNUSED, ANGLE_W'($urandom()), HEAD_W'($urandom()));
        end
        n = $urandom_range(1, 12);
        for (int j = 0; j < n; j++) begin
          if ($urandom_range(0, 19) == 0) begin
            send_turn_item(KIND_UNUSED, ANGLE_W'($urandom()), HEAD_W'($urandom()));
          end else if ($urandom_range(0, 4) == 0) begin
            send_turn_item(KIND_SAMPLE, ANGLE_W'($urandom()), random_heading());
            sent++;
          end else begin
            send_turn_item(KIND_SAMPLE, ANGLE_W'($urandom()),
                           heading_near(tol_q + (6000 >> j) + 1));
            sent++;
          end
        end
      end
      drain_pipeline();
    end
  endtask

  initial begin
    gain_p_q = longint'(GAIN_P_RST);
    gain_i_q = longint'(GAIN_I_RST);
    gain_d_q = longint'(GAIN_D_RST);
    tol_q = int'(TOLERANCE_RST);
    plim_q = int'(POWER_LIMIT_RST);
    target_q = 0;
    esum_q = 0;
    last_err_q = 0;
    moving_q = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_defaults_and_wrap();
    test_config_extremes();
    test_backpressure();
    test_integral_windup();
    test_random_moves();
    $display("%0d input transactions sent, %0d results checked, %0d moves completed",
             items_sent, checks_done, moves_finished);
    $display("covered targets, samples, wrap cases, gain extremes, drive clamping, windup, backpressure");
    if (fail_count == 0 && expected_turns.size() == 0) begin
      $display("heading_pid_turn_controller test passed");
    end else begin
      $display("heading_pid_turn_controller test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/hptc_pkg.sv
design/hptc_cfg.sv
design/hptc_track.sv
design/hptc_drive.sv
design/heading_pid_turn_controller.sv
design/hptc_chk.sv
sim/tb_heading_pid_turn_controller.sv
